// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define CHK_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hga_pkg.sv =====
// Shared types and constants of the generational handle allocator.
// No dependencies; imported by every module of the block except hga_gen_table.
package hga_pkg;

	// Configuration port geometry and register map.
	localparam int RESERVE_W = 11;
	localparam logic [RESERVE_W-1:0] RESERVE_RST = 11'd64;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_MIN_FREE_RESERVE = 1'b0;

	// Request modes.
	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_UNOPENED   = 2'd2,
		ST_QUEUE_FULL = 2'd3
	} status_t;

	// Operation decided at acceptance.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_CREATE_FRESH,
		OP_CREATE_POP,
		OP_REMOVE,
		OP_QUERY
	} op_t;

	// Control word that travels down the pipeline.
	typedef struct packed {
		logic    valid;
		op_t     op;
		status_t status;
	} ctl_t;

endpackage

// ===== hdl/hga_ctrl.sv =====
// Acceptance stage: decides each operation, keeps the free FIFO and slot counters.
// Depends on hga_pkg.
module hga_ctrl import hga_pkg::*; #(
	parameter int SLOT_COUNT = 1024,
	parameter int IDX_W = $clog2(SLOT_COUNT),
	parameter int CNT_W = $clog2(SLOT_COUNT + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 accept,
	input  logic [1:0]           mode,
	input  logic [IDX_W-1:0]     handle_index,
	input  logic [RESERVE_W-1:0] min_free_reserve,
	output ctl_t                 ctl_s1,
	output logic [IDX_W-1:0]     addr_s1
);

	localparam int CMP_W = (CNT_W > RESERVE_W) ? CNT_W : RESERVE_W;
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(SLOT_COUNT - 1);

	logic [IDX_W-1:0] q_mem [SLOT_COUNT];
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, opened_q;
	logic [IDX_W-1:0] idx_s1, q_rd_s1;

	op_t     op_d;
	status_t status_d;
	logic    above_reserve, have_fresh, queue_empty, queue_full, unopened;

	// Conditions on the current bookkeeping state.
	assign above_reserve = CMP_W'(count_q) > CMP_W'(min_free_reserve);
	assign have_fresh    = opened_q < CNT_W'(SLOT_COUNT);
	assign queue_empty   = count_q == '0;
	assign queue_full    = count_q >= CNT_W'(SLOT_COUNT);
	assign unopened      = CNT_W'(handle_index) >= opened_q;

	// Decide what the incoming request does.
	always_comb begin
		op_d = OP_NONE;
		status_d = ST_OK;
		unique case (mode)
			MODE_CREATE: begin
				if (above_reserve) begin
					op_d = OP_CREATE_POP;
				end else if (have_fresh) begin
					op_d = OP_CREATE_FRESH;
				end else if (!queue_empty) begin
					op_d = OP_CREATE_POP;
				end else begin
					status_d = ST_EXHAUSTED;
				end
			end
			MODE_REMOVE: begin
				if (unopened) begin
					status_d = ST_UNOPENED;
				end else if (queue_full) begin
					status_d = ST_QUEUE_FULL;
				end else begin
					op_d = OP_REMOVE;
				end
			end
			MODE_QUERY: begin
				if (unopened) begin
					status_d = ST_UNOPENED;
				end else begin
					op_d = OP_QUERY;
				end
			end
			default: begin
				op_d = OP_NONE;
			end
		endcase
	end

	// Counters and FIFO pointers move at the transfer of the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			opened_q <= '0;
			ctl_s1   <= '0;
		end else begin
			if (advance) begin
				ctl_s1.valid  <= accept;
				ctl_s1.op     <= op_d;
				ctl_s1.status <= status_d;
			end
			if (accept) begin
				case (op_d)
					OP_CREATE_POP: begin
						head_q  <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
					end
					OP_CREATE_FRESH: begin
						opened_q <= opened_q + 1'b1;
					end
					OP_REMOVE: begin
						tail_q  <= (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Free FIFO storage: push at the tail, registered read at the head.
	always_ff @(posedge clk) begin
		if (accept && op_d == OP_REMOVE) begin
			q_mem[tail_q] <= handle_index;
		end
		if (accept && op_d == OP_CREATE_POP) begin
			q_rd_s1 <= q_mem[head_q];
		end
	end

	// Slot index for the next stage: a fresh slot or the request's own index.
	always_ff @(posedge clk) begin
		if (advance) begin
			idx_s1 <= (op_d == OP_CREATE_FRESH) ? opened_q[IDX_W-1:0] : handle_index;
		end
	end

	assign addr_s1 = (ctl_s1.op == OP_CREATE_POP) ? q_rd_s1 : idx_s1;

endmodule

// ===== hdl/hga_gen_table.sv =====
// Generation table: one entry per slot, registered read with write forwarding.
// Depends on hga_pkg only by convention of the project; no shared types used.
module hga_gen_table #(
	parameter int SLOT_COUNT = 1024,
	parameter int GEN_BITS = 16,
	parameter int IDX_W = $clog2(SLOT_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [IDX_W-1:0]    rd_addr,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_addr,
	input  logic [GEN_BITS-1:0] wr_data,
	output logic [GEN_BITS-1:0] rd_gen
);

	logic [GEN_BITS-1:0] mem [SLOT_COUNT];
	logic [GEN_BITS-1:0] rd_data_s2, fwd_data_s2;
	logic                fwd_hit_s2;

	// Storage with a read that advances with the pipeline.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (advance) begin
			rd_data_s2  <= mem[rd_addr];
			fwd_data_s2 <= wr_data;
		end
	end

	// A write landing on the address being read in the same cycle wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_s2 <= 1'b0;
		end else if (advance) begin
			fwd_hit_s2 <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_gen = fwd_hit_s2 ? fwd_data_s2 : rd_data_s2;

endmodule

// ===== hdl/generational_handle_allocator_top.sv =====
// Top level of the generational handle allocator.
// Depends on hga_pkg, hga_ctrl and hga_gen_table.

// The block takes one request per clock cycle and returns one result for each, in order.
// A result is presented once its request has passed the pipeline: the FIFO and the
// counters move at the transfer, the generation table is read in the next stage, and the
// result register loads after that. The FIFO memory sees at most one access per request
// and the generation table one read and at most one write, so the pipeline keeps up a full
// cycle rate; req_ready drops only while a finished result waits on rsp_ready.
// Both memories start undefined and need no clearing pass after reset. The register
// min_free_reserve (byte address 0, reset 64) should be written only while the block is idle.
module generational_handle_allocator_top import hga_pkg::*; #(
	parameter int SLOT_COUNT = 1024,
	parameter int GEN_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_ADDR_W-1:0]         paddr,
	input  logic [APB_DATA_W-1:0]         pwdata,
	output logic [APB_DATA_W-1:0]         prdata,
	output logic                          pready,
	// Request channel.
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    mode,
	input  logic [$clog2(SLOT_COUNT)-1:0] handle_index,
	input  logic [GEN_BITS-1:0]           handle_generation,
	// Result channel.
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [$clog2(SLOT_COUNT)-1:0] out_index,
	output logic [GEN_BITS-1:0]           out_generation,
	output logic                          is_alive,
	output logic [1:0]                    status
);

	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic [RESERVE_W-1:0] reserve_q;
	logic                 advance, accept, cfg_write;

	ctl_t                ctl_s1, ctl_s2;
	logic [IDX_W-1:0]    addr_s1, addr_s2;
	logic [GEN_BITS-1:0] hgen_s1, hgen_s2, gen_s2;
	logic                gen_wr_en;
	logic [GEN_BITS-1:0] gen_wr_data;

	logic                rsp_valid_q;
	logic [IDX_W-1:0]    out_index_q;
	logic [GEN_BITS-1:0] out_generation_q;
	logic                is_alive_q;
	status_t             status_q;

	// Configuration register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MIN_FREE_RESERVE);
	assign prdata    = (paddr[2] == REG_MIN_FREE_RESERVE) ? APB_DATA_W'(reserve_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_q <= RESERVE_RST;
		end else if (cfg_write) begin
			reserve_q <= pwdata[RESERVE_W-1:0];
		end
	end

	// The whole pipeline moves unless a result is stalled at the output.
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = advance;
	assign accept    = req_valid && advance;

	hga_ctrl #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.accept           (accept),
		.mode             (mode),
		.handle_index     (handle_index),
		.min_free_reserve (reserve_q),
		.ctl_s1           (ctl_s1),
		.addr_s1          (addr_s1)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			hgen_s1 <= handle_generation;
		end
	end

	// Generation writes retire from the second stage.
	assign gen_wr_en   = advance && ctl_s2.valid &&
	                     (ctl_s2.op == OP_CREATE_FRESH || ctl_s2.op == OP_REMOVE);
	assign gen_wr_data = (ctl_s2.op == OP_CREATE_FRESH) ? '0 : gen_s2 + 1'b1;

	hga_gen_table #(
		.SLOT_COUNT(SLOT_COUNT),
		.GEN_BITS  (GEN_BITS)
	) u_gen_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rd_addr (addr_s1),
		.wr_en   (gen_wr_en),
		.wr_addr (addr_s2),
		.wr_data (gen_wr_data),
		.rd_gen  (gen_s2)
	);

	// Second stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			addr_s2 <= addr_s1;
			hgen_s2 <= hgen_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q         <= ctl_s2.status;
			out_index_q      <= '0;
			out_generation_q <= '0;
			is_alive_q       <= 1'b0;
			case (ctl_s2.op)
				OP_CREATE_FRESH: begin
					out_index_q <= addr_s2;
				end
				OP_CREATE_POP: begin
					out_index_q      <= addr_s2;
					out_generation_q <= gen_s2;
				end
				OP_QUERY: begin
					is_alive_q <= (gen_s2 == hgen_s2);
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign out_index      = out_index_q;
	assign out_generation = out_generation_q;
	assign is_alive       = is_alive_q;
	assign status         = status_q;

endmodule

// ===== hdl/hga_checker.sv =====
// Port-level checker for the generational handle allocator, bound to the top level.
// Depends on hga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hga_checker import hga_pkg::*; #(
	parameter int SLOT_COUNT = 1024,
	parameter int GEN_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [$clog2(SLOT_COUNT)-1:0] out_index,
	input logic [GEN_BITS-1:0]           out_generation,
	input logic                          is_alive,
	input logic [1:0]                    status
);

	// A stalled result stays valid with its index, generation and status unchanged.
	`CHK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_index) && $stable(out_generation) && $stable(status), "stalled result changed")

	// A live handle is only ever reported with status ok.
	`CHK_IMPL(a_alive_ok, rsp_valid && is_alive, status == ST_OK, "alive with error status")

	// Any error status carries no handle.
	`CHK_IMPL(a_err_empty, rsp_valid && status != ST_OK, out_index == '0 && out_generation == '0 && !is_alive, "error result carries data")

	// A result with a nonzero generation and an alive flag never appear as one result.
	`CHK_IMPL(a_create_query, rsp_valid && out_generation != '0, !is_alive, "create and query mixed")

endmodule

bind generational_handle_allocator_top hga_checker #(
	.SLOT_COUNT(SLOT_COUNT),
	.GEN_BITS  (GEN_BITS)
) u_hga_checker (.*);

// ===== tb/sv/tb_generational_handle_allocator_top.sv =====
// Self-checking testbench for the generational handle allocator top level.
// Depends on hga_pkg and generational_handle_allocator_top; it predicts every result
// itself and compares each result transfer in order against the predicted handle.
`timescale 1ns / 100ps

module tb_generational_handle_allocator_top;
	import hga_pkg::*;

	localparam int SLOT_COUNT = 1024;
	localparam int GEN_BITS = 16;
	localparam int IDX_W = 10;
	localparam logic [1:0] MODE_UNDEFINED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] RESERVE_ADDR = APB_ADDR_W'(4 * REG_MIN_FREE_RESERVE);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REQ_SLOTS = 4;
	localparam int EXP_SLOTS = 8;

	typedef struct packed {
		logic [1:0]          op_mode;
		logic [IDX_W-1:0]    index;
		logic [GEN_BITS-1:0] generation;
	} handle_request_t;

	typedef struct packed {
		logic [IDX_W-1:0]    index;
		logic [GEN_BITS-1:0] generation;
		logic                alive;
		status_t             st;
	} handle_result_t;

	// Clock, reset and all block inputs start at known values.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] mode = '0;
	logic [IDX_W-1:0] handle_index = '0;
	logic [GEN_BITS-1:0] handle_generation = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [IDX_W-1:0] out_index;
	logic [GEN_BITS-1:0] out_generation;
	logic is_alive;
	logic [1:0] status;

	// Stimulus and checking state: ring buffers with free-running write and read counts.
	handle_request_t req_buf[REQ_SLOTS];
	int req_wr = 0;
	int req_rd = 0;
	handle_result_t exp_buf[EXP_SLOTS];
	int exp_wr = 0;
	int exp_rd = 0;
	handle_request_t next_req;
	handle_result_t want_handle;
	logic req_taken = 1'b0;
	int req_gap = 0;
	int rsp_hold = 0;
	logic idle_on = 1'b1;
	int items_queued = 0;
	int errors = 0;
	int cycle_count = 0;

	// Predicted allocator state.
	logic [GEN_BITS-1:0] gen_table[SLOT_COUNT];
	logic [IDX_W-1:0] freed_fifo[SLOT_COUNT];
	logic [IDX_W-1:0] fifo_head = '0;
	logic [IDX_W-1:0] fifo_tail = '0;
	int fifo_count = 0;
	int opened = 0;
	logic [RESERVE_W-1:0] reserve_limit = RESERVE_RST;
	int n_exhausted = 0;
	int n_queue_full = 0;

	generational_handle_allocator_top #(
		.SLOT_COUNT(SLOT_COUNT),
		.GEN_BITS(GEN_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.mode(mode),
		.handle_index(handle_index),
		.handle_generation(handle_generation),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.out_index(out_index),
		.out_generation(out_generation),
		.is_alive(is_alive),
		.status(status)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Counts a failure; only the first ten are described.
	function automatic void report_mismatch(input string msg);
		errors++;
		if (errors <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [IDX_W-1:0] pop_freed();
		logic [IDX_W-1:0] slot;
		slot = freed_fifo[fifo_head];
		fifo_head++;
		fifo_count--;
		return slot;
	endfunction

	// Applies one accepted request to the predicted state and returns its result.
	function automatic handle_result_t serve_request(input handle_request_t rq);
		handle_result_t r;
		r = '0;
		case (rq.op_mode)
			MODE_CREATE: begin
				if (fifo_count > reserve_limit) begin
					r.index = pop_freed();
					r.generation = gen_table[r.index];
				end else if (opened < SLOT_COUNT) begin
					r.index = IDX_W'(opened);
					gen_table[opened] = '0;
					opened++;
				end else if (fifo_count > 0) begin
					r.index = pop_freed();
					r.generation = gen_table[r.index];
				end else begin
					r.st = ST_EXHAUSTED;
					n_exhausted++;
				end
			end
			MODE_REMOVE: begin
				if (rq.index >= opened) begin
					r.st = ST_UNOPENED;
				end else if (fifo_count >= SLOT_COUNT) begin
					r.st = ST_QUEUE_FULL;
					n_queue_full++;
				end else begin
					gen_table[rq.index] = gen_table[rq.index] + 1'b1;
					freed_fifo[fifo_tail] = rq.index;
					fifo_tail++;
					fifo_count++;
				end
			end
			MODE_QUERY: begin
				if (rq.index >= opened) r.st = ST_UNOPENED;
				else r.alive = (gen_table[rq.index] == rq.generation);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Request driver: loads the next pending item once the current one has transferred.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap != 0) begin
				req_valid <= 1'b0;
				req_gap <= req_gap - 1;
			end else if (req_wr != req_rd) begin
				next_req = req_buf[req_rd % REQ_SLOTS];
				req_rd++;
				mode <= next_req.op_mode;
				handle_index <= next_req.index;
				handle_generation <= next_req.generation;
				req_valid <= 1'b1;
				req_gap <= gap_len();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (rsp_hold != 0) begin
			rsp_ready <= 1'b0;
			rsp_hold <= rsp_hold - 1;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			rsp_ready <= 1'b0;
			rsp_hold <= gap_len();
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Monitor: predicts on each request transfer and checks each result transfer.
	always @(posedge clk) begin
		req_taken <= req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				exp_buf[exp_wr % EXP_SLOTS] =
					serve_request({mode, handle_index, handle_generation});
				exp_wr++;
			end
			if (rsp_valid && rsp_ready) begin
				if (exp_wr == exp_rd) begin
					report_mismatch($sformatf("unexpected result idx %0d gen %0d alive %0b status %0d",
						out_index, out_generation, is_alive, status));
				end else begin
					want_handle = exp_buf[exp_rd % EXP_SLOTS];
					exp_rd++;
					if (out_index !== want_handle.index || out_generation !== want_handle.generation ||
							is_alive !== want_handle.alive || status !== want_handle.st)
						report_mismatch($sformatf(
							"expected idx %0d gen %0d alive %0b status %0d, got %0d %0d %0b %0d",
							want_handle.index, want_handle.generation, want_handle.alive,
							want_handle.st, out_index, out_generation, is_alive, status));
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Keeps the pending buffer short so that generated items see nearly current state.
	task automatic push_request(input logic [1:0] m, input logic [IDX_W-1:0] i,
			input logic [GEN_BITS-1:0] g);
		while (req_wr - req_rd >= 2) @(negedge clk);
		req_buf[req_wr % REQ_SLOTS] = {m, i, g};
		req_wr++;
		items_queued++;
	endtask

	// Random items, mostly aimed at opened slots and current generations.
	task automatic mixed_items(input int count, input int create_pct, input int remove_pct);
		int r;
		logic [1:0] m;
		logic [IDX_W-1:0] i;
		logic [GEN_BITS-1:0] g;
		for (int k = 0; k < count; k++) begin
			if (items_queued % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < create_pct) m = MODE_CREATE;
			else if (r < create_pct + remove_pct) m = MODE_REMOVE;
			else if (r < 96) m = MODE_QUERY;
			else m = MODE_UNDEFINED;
			if (opened > 0 && $urandom_range(0, 9) != 0) i = IDX_W'($urandom_range(0, opened - 1));
			else i = IDX_W'($urandom);
			r = $urandom_range(0, 99);
			if (i < opened && r < 60) g = gen_table[i];
			else if (i < opened && r < 75) g = gen_table[i] - 1'b1;
			else g = GEN_BITS'($urandom);
			push_request(m, i, g);
		end
	endtask

	// Returns once no item is pending, in flight or awaiting its result.
	task automatic wait_idle();
		do @(posedge clk);
		while (req_wr != req_rd || req_valid || exp_wr != exp_rd);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_reserve_readback(input logic [RESERVE_W-1:0] want);
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = RESERVE_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got !== APB_DATA_W'(want))
			report_mismatch($sformatf("min_free_reserve reads %0d, expected %0d", got, want));
	endtask

	// Register write followed by a read back of the same register.
	task automatic write_reserve(input logic [RESERVE_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = RESERVE_ADDR;
		pwdata = APB_DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		reserve_limit = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		check_reserve_readback(value);
	endtask

	initial begin
		int target;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_reserve_readback(RESERVE_RST);

		// Directed items at the reset reserve: unopened slots, undefined mode,
		// stale and current handles, and a handle removed twice.
		push_request(MODE_QUERY, 10'd0, 16'd0);
		push_request(MODE_REMOVE, 10'd1023, 16'd0);
		push_request(MODE_UNDEFINED, 10'd1023, 16'hFFFF);
		push_request(MODE_CREATE, 10'd1023, 16'hFFFF);
		push_request(MODE_CREATE, 10'd0, 16'd0);
		push_request(MODE_QUERY, 10'd0, 16'd0);
		push_request(MODE_QUERY, 10'd0, 16'hFFFF);
		push_request(MODE_QUERY, 10'd2, 16'd0);
		push_request(MODE_REMOVE, 10'd1, 16'd0);
		push_request(MODE_REMOVE, 10'd1, 16'd0);
		push_request(MODE_QUERY, 10'd1, 16'd2);
		push_request(MODE_QUERY, 10'd1, 16'd1);
		push_request(MODE_CREATE, 10'd0, 16'd0);
		push_request(MODE_REMOVE, 10'd2, 16'hFFFF);
		push_request(MODE_UNDEFINED, 10'd0, 16'd0);
		wait_idle();

		// With no reserve the freed indices come back at once, duplicates included.
		write_reserve(11'd0);
		push_request(MODE_CREATE, 10'd0, 16'd0);
		push_request(MODE_CREATE, 10'd0, 16'd0);
		push_request(MODE_CREATE, 10'd0, 16'd0);
		push_request(MODE_CREATE, 10'd0, 16'd0);
		push_request(MODE_QUERY, 10'd1, 16'd2);
		mixed_items(80, 35, 35);
		wait_idle();

		write_reserve(11'd3);
		mixed_items(60, 35, 35);
		wait_idle();

		// Reserve equal to the slot count: open every slot, fall back to the freed queue, then run dry.
		write_reserve(11'd1024);
		target = n_exhausted + 3;
		while (n_exhausted < target) mixed_items(1, 97, 1);
		wait_idle();

		// Removes dominate until the freed queue has rejected three removes as full.
		target = n_queue_full + 3;
		while (n_queue_full < target) mixed_items(1, 2, 96);
		wait_idle();

		// Reserve one below capacity takes the first create from a full queue.
		write_reserve(11'd1023);
		mixed_items(12, 90, 5);
		wait_idle();

		write_reserve(11'd0);
		mixed_items(60, 35, 35);
		wait_idle();
		repeat (8) @(posedge clk);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
